// ----- sv/sfd_pkg.sv -----
package sfd_pkg;

	localparam int unsigned STORE_DEPTH_DEF = 65536;
	localparam int unsigned SAMPLE_BITS_DEF = 24;

	// configuration port
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 8;
	localparam logic [IDX_W-1:0] REG_DELAY = 8'd0;
	localparam logic [IDX_W-1:0] REG_GAIN  = 8'd1;
	localparam logic [CFG_W-1:0] DLY_RST   = 16'd22050;
	localparam logic [CFG_W-1:0] GAIN_RST  = 16'd32768;

	// gain is unsigned Q0.16
	localparam int unsigned GAIN_FRAC = 16;

	// output queue
	localparam int unsigned OQ_DEPTH = 4;

	// per-lane control, shared by both channels
	typedef struct packed {
		logic acc;     // new frame enters stage 1
		logic adv1;    // stage 1 moves on to stage 2
		logic use_rd;  // delayed entry was written since reset
		logic fwd;     // take delayed entry from the last-write register
		logic wr;      // stage 2 writes its scaled sample
	} lane_ctl_t;

endpackage

// ----- sv/stereo_feedback_delay.sv -----
// Stereo feedback echo (feedback comb filter), one left and one right lane.
// Input frames arrive on s_tvalid/s_tready/s_tdata, results leave on
// m_tvalid/m_tready/m_tdata, one result frame per input frame, in order.
// The cfg channel writes the delay in samples (index 0) and the Q0.16
// feedback gain (index 1); write only while no frame is in flight.
// An accepted frame waits in stage 1, then its result goes into the output
// queue, from which it is offered on m_tdata.
// Throughput: one frame per cycle while the output queue has room and no
// store hazard holds stage 1. When the delay modulo the depth is 1 the entry a
// frame reads is the one the frame before it writes, and the add / multiply /
// store loop through stage 2 holds each frame until that write is done. After
// a delay write s_tready stays low while the delay is reduced modulo the depth.
// Reset clears the write pointer and the fill flag; the stores themselves are
// not swept, entries not yet written since reset read as zero. Registers
// return to delay 22050 and gain 32768.
// When the receiver stalls, up to four frames wait in the output queue and
// s_tready drops once the queue and stage 1 hold four.
module stereo_feedback_delay import sfd_pkg::*; #(
	parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int unsigned TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [TDW-1:0]   s_tdata,   // left_sample, right_sample, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [TDW-1:0]   m_tdata,   // left_out, right_out, zero pad
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam int unsigned LW = $clog2(OQ_DEPTH + 1);

	logic [AW-1:0]    dly;
	logic [CFG_W-1:0] gain;
	logic             busy;

	logic [AW-1:0] wp_q;
	logic          full_q;
	logic          v_s1;
	logic [AW-1:0] rd_s1;
	logic [AW-1:0] wp_s1;
	logic          use_s1;
	logic          v_s2;
	logic [AW-1:0] wp_s2;
	logic          lw_v_q;
	logic [AW-1:0] lw_addr_q;

	logic [AW:0]   rd_wide;
	logic [AW-1:0] rd_in;
	logic          use_in;
	logic [AW-1:0] raddr;
	logic          hazard;
	logic          adv1;
	logic          acc;
	logic          room;
	logic [LW-1:0] lvl;
	lane_ctl_t     ctl;

	logic signed [SB-1:0] y_l;
	logic signed [SB-1:0] y_r;
	logic [2*SB-1:0]      q_dout;

	sfd_cfg #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dly       (dly),
		.gain      (gain),
		.busy      (busy)
	);

	// read address: write pointer minus the delay, wrapped
	always_comb begin
		if (wp_q >= dly) begin
			rd_wide = {1'b0, wp_q} - {1'b0, dly};
		end else begin
			rd_wide = {1'b0, wp_q} + (AW + 1)'(STORE_DEPTH) - {1'b0, dly};
		end
		rd_in  = rd_wide[AW-1:0];
		use_in = full_q || (rd_in < wp_q);
	end

	// stage 2 has not stored the entry stage 1 needs yet
	assign hazard   = v_s1 && v_s2 && (wp_s2 == rd_s1);
	assign adv1     = v_s1 && !hazard;
	assign s_tready = !busy && room && !hazard;
	assign acc      = s_tvalid && s_tready;
	assign raddr    = acc ? rd_in : rd_s1;

	always_comb begin
		ctl.acc    = acc;
		ctl.adv1   = adv1;
		ctl.use_rd = use_s1;
		ctl.fwd    = lw_v_q && (lw_addr_q == rd_s1);
		ctl.wr     = v_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			lw_v_q <= 1'b0;
		end else begin
			if (acc) begin
				if (wp_q == AW'(STORE_DEPTH - 1)) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			v_s2 <= adv1;
			if (v_s2) begin
				lw_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1  <= rd_in;
			wp_s1  <= wp_q;
			use_s1 <= use_in;
		end
		if (adv1) begin
			wp_s2 <= wp_s1;
		end
		if (v_s2) begin
			lw_addr_q <= wp_s2;
		end
	end

	sfd_lane #(
		.SAMPLE_BITS (SB),
		.STORE_DEPTH (STORE_DEPTH)
	) u_lane_l (
		.clk    (clk),
		.ctl    (ctl),
		.raddr  (raddr),
		.waddr  (wp_s2),
		.sample ($signed(s_tdata[SB-1:0])),
		.gain   (gain),
		.y      (y_l)
	);

	sfd_lane #(
		.SAMPLE_BITS (SB),
		.STORE_DEPTH (STORE_DEPTH)
	) u_lane_r (
		.clk    (clk),
		.ctl    (ctl),
		.raddr  (raddr),
		.waddr  (wp_s2),
		.sample ($signed(s_tdata[2*SB-1:SB])),
		.gain   (gain),
		.y      (y_r)
	);

	sfd_outq #(
		.W (2 * SB)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv1),
		.din       ({y_r, y_l}),
		.pend      (v_s1),
		.room      (room),
		.lvl       (lvl),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (q_dout)
	);

	assign m_tdata = TDW'(q_dout);

	// a frame held in stage 1 keeps its read address for the retry
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hazard |=> v_s1 && $stable(rd_s1))
		else $error("stage 1 lost its frame during a store hazard");

	// queued results plus the frame in stage 1 never exceed the queue
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl + LW'(v_s1)) <= LW'(OQ_DEPTH))
		else $error("output queue overcommitted");

	// the store loop never forwards while the producing frame is unwritten
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && v_s2 |-> wp_s2 != rd_s1)
		else $error("frame left stage 1 ahead of its store write");

endmodule

// ----- sv/sfd_ram.sv -----
module sfd_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 65536,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/sfd_cfg.sv -----
module sfd_cfg import sfd_pkg::*; #(
	parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
	localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output logic [AW-1:0]    dly,
	output logic [CFG_W-1:0] gain,
	output logic             busy
);

	localparam int unsigned RCP_SH = 32;
	localparam int unsigned MW     = CFG_W + RCP_SH;
	localparam logic [RCP_SH-1:0] RCP = RCP_SH'((64'd1 << RCP_SH) / 64'(STORE_DEPTH));
	localparam logic [CFG_W-1:0] DLY_MOD_RST = CFG_W'(DLY_RST % STORE_DEPTH);

	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] raw_q;
	logic [CFG_W-1:0] quo_q;
	logic             ph_q;
	logic             busy_q;
	logic [CFG_W-1:0] gain_q;
	logic             wr;
	logic [MW-1:0]    prod;
	logic [CFG_W-1:0] part;
	logic [CFG_W-1:0] fix;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	// delay modulo the depth: reciprocal multiply gives the quotient or one
	// less, a single compare and subtract finishes the remainder
	assign prod = MW'(raw_q) * MW'(RCP);
	assign part = raw_q - CFG_W'(32'(quo_q) * STORE_DEPTH);
	assign fix  = (32'(part) >= STORE_DEPTH) ? part - CFG_W'(STORE_DEPTH) : part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= DLY_MOD_RST;
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			gain_q <= GAIN_RST;
		end else begin
			if (wr && cfg_index == REG_GAIN) begin
				gain_q <= cfg_data;
			end
			if (wr && cfg_index == REG_DELAY) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
			end else if (busy_q) begin
				ph_q <= 1'b1;
				if (ph_q) begin
					rem_q  <= fix;
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && cfg_index == REG_DELAY) begin
			raw_q <= cfg_data;
		end
		if (busy_q && !ph_q) begin
			quo_q <= prod[MW-1:RCP_SH];
		end
	end

	assign dly  = AW'(rem_q);
	assign gain = gain_q;
	assign busy = busy_q;

endmodule

// ----- sv/sfd_lane.sv -----
module sfd_lane import sfd_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
	localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
	input  logic                          clk,
	input  lane_ctl_t                     ctl,
	input  logic [AW-1:0]                 raddr,
	input  logic [AW-1:0]                 waddr,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [CFG_W-1:0]              gain,
	output logic signed [SAMPLE_BITS-1:0] y
);

	localparam int unsigned SB = SAMPLE_BITS;
	localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

	logic signed [SB-1:0]      x_s1;
	logic signed [SB-1:0]      y_s2;
	logic signed [SB-1:0]      lw_q;
	logic [SB-1:0]             rdata;
	logic signed [SB-1:0]      fb;
	logic signed [SB:0]        sum;
	logic signed [SB+CFG_W:0]  prod;
	logic signed [SB-1:0]      w;

	sfd_ram #(
		.WIDTH (SB),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.wr),
		.waddr (waddr),
		.wdata (w),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (!ctl.use_rd) begin
			fb = '0;
		end else if (ctl.fwd) begin
			fb = lw_q;
		end else begin
			fb = $signed(rdata);
		end
		sum = {x_s1[SB-1], x_s1} + {fb[SB-1], fb};
		if (sum[SB] != sum[SB-1]) begin
			y = sum[SB] ? SMP_MIN : SMP_MAX;
		end else begin
			y = sum[SB-1:0];
		end
	end

	// arithmetic shift of the product rounds toward minus infinity
	assign prod = y_s2 * $signed({1'b0, gain});
	assign w    = prod[SB+GAIN_FRAC-1:GAIN_FRAC];

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			x_s1 <= sample;
		end
		if (ctl.adv1) begin
			y_s2 <= y;
		end
		if (ctl.wr) begin
			lw_q <= w;
		end
	end

endmodule

// ----- sv/sfd_outq.sv -----
module sfd_outq import sfd_pkg::*; #(
	parameter int unsigned W = 2 * SAMPLE_BITS_DEF,
	localparam int unsigned LW = $clog2(OQ_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  din,
	input  logic          pend,
	output logic          room,
	output logic [LW-1:0] lvl,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [W-1:0]  dout
);

	localparam int unsigned PW = $clog2(OQ_DEPTH);

	logic [W-1:0]  q_q [OQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [LW-1:0] cnt_q;
	logic          pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign dout      = q_q[rptr_q];
	assign lvl       = cnt_q;
	// a frame still in stage 1 has a slot held for it
	assign room      = (cnt_q + LW'(pend)) < LW'(OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wptr_q] <= din;
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import sfd_pkg::*;

	localparam int unsigned SW = 24;
	localparam int unsigned DW = 48;
	localparam int unsigned LINE_DEPTH = 65536;
	localparam int IDLE_PCT = 21;
	localparam int STALL_LEN = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_FRAMES = 173;
	localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] S_MIN = 24'sh800000;
	localparam logic [IDX_W-1:0] IDX_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;   // left_sample, right_sample
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DW-1:0] m_tdata;        // left_out, right_out
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	stereo_feedback_delay u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// echo model state
	logic signed [SW-1:0] left_line [0:LINE_DEPTH-1];
	logic signed [SW-1:0] right_line [0:LINE_DEPTH-1];
	logic [15:0] head_ptr = '0;
	logic [CFG_W-1:0] delay_len = DLY_RST;
	logic [CFG_W-1:0] fb_gain = GAIN_RST;

	logic [DW-1:0] frames_pending [$];
	logic [DW-1:0] out_frames_due [$];
	int queued_cnt = 0;
	int accepted_cnt = 0;
	int results_seen = 0;
	int fail_cnt = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic signed [SW-1:0] clip_sum(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		logic signed [SW:0] s;
		s = a + b;
		if (s > S_MAX)
			return S_MAX;
		if (s < S_MIN)
			return S_MIN;
		return s[SW-1:0];
	endfunction

	// arithmetic shift floors the Q0.16 product
	function automatic logic signed [SW-1:0] apply_gain(input logic signed [SW-1:0] y);
		longint p;
		p = longint'(y) * longint'({1'b0, fb_gain});
		p = p >>> GAIN_FRAC;
		return p[SW-1:0];
	endfunction

	function automatic logic [DW-1:0] echo_frame(input logic [DW-1:0] din);
		logic [15:0] rd;
		logic signed [SW-1:0] yl, yr;
		rd = head_ptr - delay_len;
		yl = clip_sum(din[SW-1:0], left_line[rd]);
		yr = clip_sum(din[DW-1:SW], right_line[rd]);
		left_line[head_ptr] = apply_gain(yl);
		right_line[head_ptr] = apply_gain(yr);
		head_ptr = head_ptr + 16'd1;
		return {yr, yl};
	endfunction

	function automatic logic [SW-1:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return SW'($urandom());
		if (pick < 17)
			return SW'($urandom_range(0, 511) - 256);
		if (pick == 17)
			return S_MAX;
		if (pick == 18)
			return S_MIN;
		return '0;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				out_frames_due.push_back(echo_frame(s_tdata));
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (frames_pending.size() > 0 &&
						(no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata <= frames_pending.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		logic [DW-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (out_frames_due.size() == 0) begin
					$error("unexpected result: left_out %0d, right_out %0d",
						$signed(m_tdata[SW-1:0]), $signed(m_tdata[DW-1:SW]));
					fail_cnt++;
				end else begin
					want = out_frames_due.pop_front();
					if (m_tdata[SW-1:0] !== want[SW-1:0]) begin
						$error("left_out: expected %0d, actual %0d",
							$signed(want[SW-1:0]), $signed(m_tdata[SW-1:0]));
						fail_cnt++;
					end
					if (m_tdata[DW-1:SW] !== want[DW-1:SW]) begin
						$error("right_out: expected %0d, actual %0d",
							$signed(want[DW-1:SW]), $signed(m_tdata[DW-1:SW]));
						fail_cnt++;
					end
				end
				results_seen++;
				// long hold-off so the output queue fills and s_tready drops
				if (results_seen % 500 == 250)
					stall_left = STALL_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	task automatic push_frame(input logic [SW-1:0] l, input logic [SW-1:0] r);
		frames_pending.push_back({r, l});
		queued_cnt++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DELAY: delay_len = val;
			REG_GAIN:  fb_gain = val;
			default: ;
		endcase
	endtask

	// wait until every request is in and every result is out
	task automatic drain();
		while (accepted_cnt != queued_cnt || out_frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int dly;
		int gsel;
		logic [CFG_W-1:0] gval;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			left_line[i] = '0;
			right_line[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, lines still empty
		push_frame('0, '0);
		push_frame(S_MAX, S_MIN);
		push_frame(S_MIN, S_MAX);
		push_frame('1, 24'd1);
		push_frame(24'd1, '1);
		drain();

		// out-of-range indexes are dropped
		write_reg(REG_GAIN + 1'b1, 16'hFFFF);
		write_reg(IDX_TOP, 16'h0001);
		// shortest loop, full gain: saturation both ways
		write_reg(REG_DELAY, 16'd1);
		write_reg(REG_GAIN, 16'hFFFF);
		push_frame(S_MAX, S_MAX);
		push_frame(S_MAX, S_MAX);
		push_frame(S_MAX, S_MIN);
		push_frame(S_MIN, S_MIN);
		push_frame(S_MIN, S_MIN);
		push_frame(S_MIN, S_MAX);
		push_frame(24'h555555, 24'hAAAAAA);
		push_frame(24'hAAAAAA, 24'h555555);
		drain();

		// zero delay means a full line; zero gain stores zeros
		write_reg(REG_DELAY, 16'd0);
		write_reg(REG_GAIN, 16'd0);
		push_frame(S_MAX, S_MIN);
		push_frame(24'h123456, 24'hFEDCBA);
		push_frame(S_MIN, S_MAX);
		drain();

		write_reg(REG_DELAY, 16'hFFFF);
		write_reg(REG_GAIN, 16'hFFFF);
		push_frame(S_MAX, S_MAX);
		push_frame(S_MIN, S_MIN);
		push_frame(24'h000001, 24'hFFFFFF);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: dly = 1;
				1: dly = 2;
				2: dly = $urandom_range(3, 40);
				3: dly = $urandom_range(41, 400);
				4: dly = $urandom_range(0, 65535);
				default: dly = 0;
			endcase
			gsel = $urandom_range(0, 3);
			if (gsel == 0)
				gval = '1;
			else if (gsel == 1)
				gval = CFG_W'($urandom_range(49152, 65535));
			else
				gval = CFG_W'($urandom());
			if ($urandom_range(0, 3) == 0)
				write_reg(IDX_W'($urandom_range(REG_GAIN + 1, IDX_TOP)), CFG_W'($urandom()));
			write_reg(REG_DELAY, CFG_W'(dly));
			write_reg(REG_GAIN, gval);
			no_idle = (ph == 3);
			for (int k = 0; k < PHASE_FRAMES; k++)
				push_frame(rand_sample(), rand_sample());
			drain();
			no_idle = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (fail_cnt == 0 && out_frames_due.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
